FILE: src/ipt_pkg.sv
// Shared types and codes for the inverted page table.
// Depends on nothing; used by inverted_page_table and the testbench.
package ipt_pkg;

	localparam int PID_W  = 8;
	localparam int PAGE_W = 20;
	localparam int WB_W   = 5;

	// Action codes carried by a request.
	localparam logic ACT_ACCESS = 1'b0;
	localparam logic ACT_FLUSH  = 1'b1;

	// Largest write-back count that the result field can report.
	localparam logic [WB_W-1:0] WB_MAX = '1;

	// Contents of one slot of the table, kept in the slot memory.
	typedef struct packed {
		logic [PID_W-1:0]  process;
		logic [PAGE_W-1:0] page;
		logic              dirty;
	} entry_t;

endpackage

FILE: src/inverted_page_table.sv
// Inverted page table: slot memory, valid bits and the scanning sequencer.
// Depends on ipt_pkg for the slot entry type, the action codes and widths.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------
//  request | req_valid, req_stall | action, process_id, page, is_write
//  result  | rsp_valid, rsp_stall | fault, dropped, writebacks
//
// Every request walks the whole slot memory once, one slot a cycle through
// its single registered read port; a hit on an access ends the walk at once.
// arst_n empties the table by clearing the valid bits only; slot contents
// are not cleared, as a slot that is not valid is never looked at.
// req_stall is high while a request is being worked on; a finished result
// waits in the output register, and the next request is taken meanwhile.
module inverted_page_table #(
	parameter int HALF_SLOTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       action,
	input  logic [ipt_pkg::PID_W-1:0]  process_id,
	input  logic [ipt_pkg::PAGE_W-1:0] page,
	input  logic                       is_write,
	output logic                       rsp_valid,
	input  logic                       rsp_stall,
	output logic                       fault,
	output logic                       dropped,
	output logic [ipt_pkg::WB_W-1:0]   writebacks
);

	localparam int SLOTS = 2 * HALF_SLOTS;
	localparam int IDX_W = $clog2(SLOTS);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	state_t state_q;

	// The request being worked on.
	logic                       req_action_q;
	logic [ipt_pkg::PID_W-1:0]  req_process_q;
	logic [ipt_pkg::PAGE_W-1:0] req_page_q;
	logic                       req_write_q;

	// Read side of the walk: idx_q is the slot being read, and the _s1
	// registers describe the slot whose data is on the memory output.
	logic [IDX_W-1:0] idx_q;
	logic             issue_done_q;
	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	ipt_pkg::entry_t  rdata_s1;

	// Findings gathered as the walk goes on.
	logic             free_found_q;
	logic [IDX_W-1:0] free_q;
	logic [ipt_pkg::WB_W-1:0] wb_q;

	logic                     res_fault_q;
	logic                     res_dropped_q;
	logic [ipt_pkg::WB_W-1:0] res_wb_q;

	logic                     rsp_valid_q;
	logic                     fault_q;
	logic                     dropped_q;
	logic [ipt_pkg::WB_W-1:0] writebacks_q;

	logic [SLOTS-1:0] valid_q;
	ipt_pkg::entry_t  mem_q [SLOTS];

	// Compare of the slot on the memory output against the request.
	logic                     ent_valid;
	logic                     proc_match;
	logic                     page_match;
	logic                     last_cmp;
	logic                     free_now;
	logic [IDX_W-1:0]         free_idx;
	logic [ipt_pkg::WB_W-1:0] wb_next;
	logic                     is_flush;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	ipt_pkg::entry_t  mem_wdata;

	always_comb begin
		ent_valid  = valid_q[cmp_idx_s1];
		proc_match = ent_valid && (rdata_s1.process == req_process_q);
		page_match = proc_match && (rdata_s1.page == req_page_q);
		last_cmp   = (cmp_idx_s1 == LAST_IDX);
		is_flush   = (req_action_q == ipt_pkg::ACT_FLUSH);
		// The slot now being compared still counts when it is the first free one.
		free_now   = free_found_q || !ent_valid;
		free_idx   = free_found_q ? free_q : cmp_idx_s1;
		wb_next    = wb_q;
		if (proc_match && rdata_s1.dirty && (wb_q != ipt_pkg::WB_MAX)) begin
			wb_next = wb_q + ipt_pkg::WB_W'(1);
		end
	end

	// A hit on a write marks the slot dirty; a miss fills the first free slot.
	always_comb begin
		mem_we          = 1'b0;
		mem_waddr       = cmp_idx_s1;
		mem_wdata.process = req_process_q;
		mem_wdata.page    = req_page_q;
		mem_wdata.dirty   = req_write_q;
		if (state_q == ST_SCAN && cmp_vld_s1 && !is_flush) begin
			if (page_match) begin
				mem_we = req_write_q;
			end else if (last_cmp && free_now) begin
				mem_we    = 1'b1;
				mem_waddr = free_idx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		rdata_s1 <= mem_q[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			valid_q       <= '0;
			idx_q         <= '0;
			issue_done_q  <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			cmp_idx_s1    <= '0;
			free_found_q  <= 1'b0;
			free_q        <= '0;
			wb_q          <= '0;
			req_action_q  <= ipt_pkg::ACT_ACCESS;
			req_process_q <= '0;
			req_page_q    <= '0;
			req_write_q   <= 1'b0;
			res_fault_q   <= 1'b0;
			res_dropped_q <= 1'b0;
			res_wb_q      <= '0;
			rsp_valid_q   <= 1'b0;
			fault_q       <= 1'b0;
			dropped_q     <= 1'b0;
			writebacks_q  <= '0;
		end else begin
			// A new result is loaded when the register is empty or being emptied.
			if (state_q == ST_FINISH && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					cmp_vld_s1 <= 1'b0;
					if (req_valid) begin
						req_action_q  <= action;
						req_process_q <= process_id;
						req_page_q    <= page;
						req_write_q   <= is_write;
						idx_q         <= '0;
						issue_done_q  <= 1'b0;
						free_found_q  <= 1'b0;
						wb_q          <= '0;
						state_q       <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// The walk is rewound as soon as its last compare is made.
					if (cmp_vld_s1 && (last_cmp || (!is_flush && page_match))) begin
						cmp_vld_s1 <= 1'b0;
						idx_q      <= '0;
					end else if (!issue_done_q) begin
						cmp_vld_s1 <= 1'b1;
						cmp_idx_s1 <= idx_q;
						if (idx_q == LAST_IDX) begin
							issue_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end else begin
						cmp_vld_s1 <= 1'b0;
					end
					if (cmp_vld_s1) begin
						if (is_flush) begin
							if (proc_match) begin
								valid_q[cmp_idx_s1] <= 1'b0;
							end
							wb_q <= wb_next;
							if (last_cmp) begin
								res_fault_q   <= 1'b0;
								res_dropped_q <= 1'b0;
								res_wb_q      <= wb_next;
								state_q       <= ST_FINISH;
							end
						end else if (page_match) begin
							res_fault_q   <= 1'b0;
							res_dropped_q <= 1'b0;
							res_wb_q      <= '0;
							state_q       <= ST_FINISH;
						end else begin
							if (!ent_valid && !free_found_q) begin
								free_found_q <= 1'b1;
								free_q       <= cmp_idx_s1;
							end
							if (last_cmp) begin
								if (free_now) begin
									valid_q[free_idx] <= 1'b1;
								end
								res_fault_q   <= 1'b1;
								res_dropped_q <= !free_now;
								res_wb_q      <= '0;
								state_q       <= ST_FINISH;
							end
						end
					end
				end
				ST_FINISH: begin
					cmp_vld_s1 <= 1'b0;
					if (!rsp_valid_q || !rsp_stall) begin
						fault_q      <= res_fault_q;
						dropped_q    <= res_dropped_q;
						writebacks_q <= res_wb_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign req_stall  = (state_q != ST_IDLE);
	assign rsp_valid  = rsp_valid_q;
	assign fault      = fault_q;
	assign dropped    = dropped_q;
	assign writebacks = writebacks_q;

`ifndef SYNTHESIS
	// A result appears only when the sequencer hands one over.
	a_rsp_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside the finishing step");

	// A dropped insertion is always a fault.
	a_dropped_fault: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (!dropped_q || fault_q))
		else $error("dropped result without a fault");

	// Write-backs are only ever reported by a flush, which never faults.
	a_wb_no_fault: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && (writebacks_q != '0)) |-> !fault_q)
		else $error("write-backs reported with a fault");

	// The walk is rewound and empty whenever the block waits for a request.
	a_idle_rewound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> ((idx_q == '0) && !cmp_vld_s1))
		else $error("slot walk not rewound while idle");
`endif

endmodule

FILE: test/page_table_monitor.sv
// Monitor for the inverted page table: watches the request and result channels,
// keeps its own copy of the slot table and checks every result against it.
// Depends on ipt_pkg for the field widths, the action codes and WB_MAX.
module page_table_monitor #(
	parameter int HALF_SLOTS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       req_valid,
	input  logic                       req_stall,
	input  logic                       action,
	input  logic [ipt_pkg::PID_W-1:0]  process_id,
	input  logic [ipt_pkg::PAGE_W-1:0] page,
	input  logic                       is_write,
	input  logic                       rsp_valid,
	input  logic                       rsp_stall,
	input  logic                       fault,
	input  logic                       dropped,
	input  logic [ipt_pkg::WB_W-1:0]   writebacks,
	output int                         mismatches,
	output int                         outstanding
);

	localparam int PID_W      = ipt_pkg::PID_W;
	localparam int PAGE_W     = ipt_pkg::PAGE_W;
	localparam int WB_W       = ipt_pkg::WB_W;
	localparam int SLOT_COUNT = 2 * HALF_SLOTS;

	typedef struct packed {
		logic            fault;
		logic            dropped;
		logic [WB_W-1:0] writebacks;
	} outcome_t;

	logic              slot_live     [SLOT_COUNT];
	logic [PID_W-1:0]  slot_owner    [SLOT_COUNT];
	logic [PAGE_W-1:0] slot_vpage    [SLOT_COUNT];
	logic              slot_modified [SLOT_COUNT];

	outcome_t expected_outcomes [$];
	int       error_count = 0;

	assign mismatches = error_count;

	// Applies one request to the shadow table and returns the outcome it causes.
	task automatic apply_request(input logic act, input logic [PID_W-1:0] pid,
			input logic [PAGE_W-1:0] pg, input logic wr, output outcome_t result);
		int              hit;
		logic [WB_W-1:0] wb;
		result = '0;
		if (act == ipt_pkg::ACT_FLUSH) begin
			wb = '0;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (slot_live[i] && slot_owner[i] == pid) begin
					if (slot_modified[i] && wb != ipt_pkg::WB_MAX)
						wb = wb + 1'b1;
					slot_live[i] = 1'b0;
				end
			end
			result.writebacks = wb;
		end else begin
			hit = -1;
			for (int i = 0; i < SLOT_COUNT; i++) begin
				if (hit < 0 && slot_live[i] && slot_owner[i] == pid && slot_vpage[i] == pg)
					hit = i;
			end
			if (hit >= 0) begin
				if (wr)
					slot_modified[hit] = 1'b1;
			end else begin
				// Page fault: take the lowest free slot, or drop the pair.
				result.fault   = 1'b1;
				result.dropped = 1'b1;
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (result.dropped && !slot_live[i]) begin
						slot_live[i]     = 1'b1;
						slot_owner[i]    = pid;
						slot_vpage[i]    = pg;
						slot_modified[i] = wr;
						result.dropped   = 1'b0;
					end
				end
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t predicted;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++)
				slot_live[i] = 1'b0;
			expected_outcomes.delete();
		end else begin
			if (req_valid && !req_stall) begin
				apply_request(action, process_id, page, is_write, predicted);
				expected_outcomes.push_back(predicted);
			end
			if (rsp_valid && !rsp_stall) begin
				if (expected_outcomes.size() == 0) begin
					error_count++;
					$display("%0t: unexpected result fault=%0b dropped=%0b writebacks=%0d",
						$time, fault, dropped, writebacks);
				end else begin
					predicted = expected_outcomes.pop_front();
					if (fault !== predicted.fault) begin
						error_count++;
						$display("%0t: fault expected %0b, actual %0b",
							$time, predicted.fault, fault);
					end
					if (dropped !== predicted.dropped) begin
						error_count++;
						$display("%0t: dropped expected %0b, actual %0b",
							$time, predicted.dropped, dropped);
					end
					if (writebacks !== predicted.writebacks) begin
						error_count++;
						$display("%0t: writebacks expected %0d, actual %0d",
							$time, predicted.writebacks, writebacks);
					end
				end
			end
		end
		outstanding = expected_outcomes.size();
	end

endmodule

FILE: test/inverted_page_table_test.sv
// Top of the inverted page table testbench: clock, reset, request stimulus and verdict.
// Depends on ipt_pkg, inverted_page_table and page_table_monitor.
module inverted_page_table_test;

	localparam int PID_W         = ipt_pkg::PID_W;
	localparam int PAGE_W        = ipt_pkg::PAGE_W;
	localparam int WB_W          = ipt_pkg::WB_W;
	localparam int HALF_SLOTS    = 8;
	localparam int SLOT_COUNT    = 2 * HALF_SLOTS;
	// Generous ceiling for the watchdog.
	localparam int CYCLE_LIMIT   = 400_000;
	// Time allowed, with room to spare, after the last result.
	localparam int DRAIN_CYCLES  = 50;
	localparam int BATCH_ITEMS   = 40;
	localparam int BATCHES       = 8;
	localparam int POOL_PIDS     = 4;
	localparam int POOL_PAGES    = 8;

	// Every input of the block starts at a known value.
	logic              clk        = 1'b0;
	logic              arst_n     = 1'b0;
	logic              req_valid  = 1'b0;
	logic              action     = ipt_pkg::ACT_ACCESS;
	logic [PID_W-1:0]  process_id = '0;
	logic [PAGE_W-1:0] page       = '0;
	logic              is_write   = 1'b0;
	logic              rsp_stall  = 1'b0;

	logic              req_stall;
	logic              rsp_valid;
	logic              fault;
	logic              dropped;
	logic [WB_W-1:0]   writebacks;

	int mismatches;
	int outstanding;
	int cycle_count        = 0;
	int sender_idle_pct    = 0;
	int receiver_stall_pct = 0;

	// The random part works on a small pool of processes and pages so that
	// hits, upgrades to dirty, full tables and dropped faults all turn up.
	// The pool is drawn afresh for every batch.
	logic [PID_W-1:0]  pid_base;
	logic [PAGE_W-1:0] page_base;
	// Processes of stray accesses; they are flushed at the end of each batch
	// so that they do not fill the table for good.
	logic [PID_W-1:0]  stray_pids [$];

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	inverted_page_table #(
		.HALF_SLOTS(HALF_SLOTS)
	) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.action     (action),
		.process_id (process_id),
		.page       (page),
		.is_write   (is_write),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.fault      (fault),
		.dropped    (dropped),
		.writebacks (writebacks)
	);

	page_table_monitor #(
		.HALF_SLOTS(HALF_SLOTS)
	) monitor (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.action      (action),
		.process_id  (process_id),
		.page        (page),
		.is_write    (is_write),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.fault       (fault),
		.dropped     (dropped),
		.writebacks  (writebacks),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	// The result side stalls at random, at the rate of the current phase.
	always @(posedge clk) begin
		rsp_stall <= ($urandom_range(0, 99) < receiver_stall_pct);
	end

	// Watchdog: a hung handshake ends the run as a failure.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Offers one request and returns at the edge at which it is taken. Idle
	// cycles are inserted beforehand at the sender's rate; valid is held and
	// the payload kept steady for as long as the block stalls.
	task automatic send_request(input logic act, input logic [PID_W-1:0] pid,
			input logic [PAGE_W-1:0] pg, input logic wr);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid  <= 1'b1;
		action     <= act;
		process_id <= pid;
		page       <= pg;
		is_write   <= wr;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Directed opening: extreme field values, a hit upgrading a clean slot,
	// a flush with junk in the fields that it ignores, a flush of a process
	// that owns nothing, a completely full table and the dropped fault.
	task automatic run_directed();
		send_request(ipt_pkg::ACT_ACCESS, 8'h00, 20'h00000, 1'b0);
		send_request(ipt_pkg::ACT_ACCESS, 8'h00, 20'h00000, 1'b1);
		send_request(ipt_pkg::ACT_ACCESS, 8'hFF, 20'hFFFFF, 1'b1);
		send_request(ipt_pkg::ACT_ACCESS, 8'hFF, 20'hFFFFF, 1'b0);
		send_request(ipt_pkg::ACT_FLUSH,  8'h00, 20'hFFFFF, 1'b1);
		send_request(ipt_pkg::ACT_FLUSH,  8'h00, 20'h00000, 1'b0);
		// Process 0xFF holds one slot; fill every other one.
		for (int i = 0; i < SLOT_COUNT - 1; i++)
			send_request(ipt_pkg::ACT_ACCESS, 8'h07, PAGE_W'(i), i[0]);
		send_request(ipt_pkg::ACT_ACCESS, 8'h07, PAGE_W'(SLOT_COUNT - 1), 1'b1);
		send_request(ipt_pkg::ACT_ACCESS, 8'hFF, 20'hFFFFF, 1'b1);
		send_request(ipt_pkg::ACT_FLUSH,  8'h07, 20'h00000, 1'b0);
		send_request(ipt_pkg::ACT_FLUSH,  8'hFF, 20'h00000, 1'b0);
	endtask

	// One random request: mostly accesses within the pool, some flushes of a
	// pool process (now and then of any process), and some stray accesses
	// with every field drawn over its whole range.
	task automatic send_random_request();
		int               pick;
		logic [PID_W-1:0] pid;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			if ($urandom_range(0, 4) == 0)
				pid = PID_W'($urandom);
			else
				pid = pid_base ^ PID_W'($urandom_range(0, POOL_PIDS - 1));
			send_request(ipt_pkg::ACT_FLUSH, pid, PAGE_W'($urandom),
				1'($urandom_range(0, 1)));
		end else if (pick < 88) begin
			send_request(ipt_pkg::ACT_ACCESS,
				pid_base ^ PID_W'($urandom_range(0, POOL_PIDS - 1)),
				page_base ^ PAGE_W'($urandom_range(0, POOL_PAGES - 1)),
				1'($urandom_range(0, 1)));
		end else begin
			pid = PID_W'($urandom);
			stray_pids.push_back(pid);
			send_request(ipt_pkg::ACT_ACCESS, pid, PAGE_W'($urandom),
				1'($urandom_range(0, 1)));
		end
	endtask

	// A batch works on a fresh pool and ends by flushing everything that it
	// may have left in the table.
	task automatic run_batch();
		pid_base  = PID_W'($urandom);
		page_base = PAGE_W'($urandom);
		repeat (BATCH_ITEMS)
			send_random_request();
		foreach (stray_pids[i])
			send_request(ipt_pkg::ACT_FLUSH, stray_pids[i], PAGE_W'($urandom),
				1'($urandom_range(0, 1)));
		stray_pids.delete();
		for (int k = 0; k < POOL_PIDS; k++)
			send_request(ipt_pkg::ACT_FLUSH, pid_base ^ PID_W'(k), PAGE_W'($urandom),
				1'($urandom_range(0, 1)));
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Three phases: a receiver that stalls more than the sender idles, the reverse,
		// and then both sides running flat out.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					sender_idle_pct    = 29;
					receiver_stall_pct = 61;
				end
				1: begin
					sender_idle_pct    = 61;
					receiver_stall_pct = 29;
				end
				default: begin
					sender_idle_pct    = 0;
					receiver_stall_pct = 0;
				end
			endcase
			if (phase == 0)
				run_directed();
			repeat (BATCHES)
				run_batch();
		end
		req_valid <= 1'b0;

		// Wait for every predicted result, then a little longer so that a
		// spurious extra result would still be caught.
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
